>>> rtl/tdpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpe_pkg
// Shared constants, packet mode codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tdpe_pkg;

    localparam int ROW_TILES_DEF  = 20;
    localparam int ROWS_DEF       = 18;
    localparam int MAP_STRIDE_DEF = 32;

    localparam int          MAX_OUT     = 24;
    localparam int          CNT_W       = $clog2(MAX_OUT + 1);
    localparam int          HDR         = 3;
    localparam int          LIT_MARK    = 80;
    localparam int          REP_SHORT   = 4;
    localparam int          REP_LONG    = 7;
    localparam int          SCORE_W     = 9;
    localparam logic [7:0]  FRAME_TAIL  = 8'hFF;
    localparam logic [15:0] BASE_RESET  = 16'h9800;

    typedef enum logic [1:0] {
        MODE_LIT,
        MODE_RUNS,
        MODE_REP4,
        MODE_REP7
    } mode_t;

    typedef struct packed {
        logic load;
        logic cmp;
        logic score;
        logic decide;
        logic emit;
        logic fend;
        logic flush;
        logic rowend;
    } tdpe_cmd_t;

    typedef struct packed {
        logic row_last;
        logic walk_first;
        logic any;
        logic frame_last;
        logic prime;
        logic emit_end;
        logic byte_ok;
        logic pend_v;
    } tdpe_stat_t;

endpackage

>>> rtl/tdpe_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpe_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tdpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 360
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tdpe_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpe_dp
// Datapath: reference frame, row buffer, backward scoring walk, forward
// packet emission walk and the output byte stage.
// ----------------------------------------------------------------------------
module tdpe_dp
    import tdpe_pkg::*;
#(
    parameter int ROW_TILES  = ROW_TILES_DEF,
    parameter int ROWS       = ROWS_DEF,
    parameter int MAP_STRIDE = MAP_STRIDE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        base_we,
    input  logic [15:0] base_wdata,
    input  logic        req_type,
    input  logic [7:0]  tile_id,
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  out_byte,
    output logic        end_of_run,
    input  tdpe_cmd_t   cmd,
    output tdpe_stat_t  st
);

    localparam int CW    = $clog2(ROW_TILES);
    localparam int NW    = $clog2(ROW_TILES + 1);
    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int DEPTH = ROWS * ROW_TILES;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [CW-1:0] LAST_COL  = CW'(ROW_TILES - 1);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // config and position
    logic [15:0] base_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [15:0] rowoff_reg;
    logic [AW-1:0] addr_reg;

    // current item
    logic [7:0] tile_reg;
    logic       prime_reg;
    logic [7:0] last_tile_reg;

    // row buffer
    logic [7:0]          row_tile_reg [ROW_TILES];
    logic [ROW_TILES-1:0] changed_reg;
    logic [ROW_TILES-1:0] eq_reg;
    logic [NW-1:0]       runlen_reg [ROW_TILES];
    logic [NW-1:0]       seg4_reg [ROW_TILES];
    logic [NW-1:0]       seg7_reg [ROW_TILES];
    logic [NW-1:0]       sublen_reg [ROW_TILES];
    mode_t               smode_reg [ROW_TILES];

    // walks
    logic [CW-1:0]      walk_reg;
    logic [NW-1:0]      rl_reg;
    logic [NW-1:0]      sl_reg;
    logic [NW-1:0]      lit4_reg;
    logic [NW-1:0]      lit7_reg;
    logic [SCORE_W-1:0] s2_reg;
    logic [SCORE_W-1:0] s4_reg;
    logic [SCORE_W-1:0] s7_reg;
    logic [SCORE_W-1:0] sum_reg;
    logic [CW-1:0]      first_reg;
    logic               any_reg;
    logic               fb_reg;
    logic [1:0]         ph_reg;
    mode_t              emode_reg;
    logic               long_reg;

    // output stage
    logic [7:0]       pend_reg;
    logic             pend_v_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             ov_reg;
    logic [7:0]       ob_reg;
    logic             oe_reg;

    logic [7:0] ref_rdata;
    logic       changed_new;

    tdpe_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ref (
        .clk   (clk),
        .we    (cmd.cmp),
        .waddr (addr_reg),
        .wdata (tile_reg),
        .re    (cmd.load),
        .raddr (addr_reg),
        .rdata (ref_rdata)
    );

    assign changed_new = !prime_reg && (ref_rdata != tile_reg);

    // neighbors of the walk column
    logic [CW-1:0] pidx;
    logic          chg;
    logic          pchg;
    logic          peq;

    assign pidx = walk_reg - 1'b1;
    assign chg  = changed_reg[walk_reg];
    assign pchg = (walk_reg != '0) && changed_reg[pidx];
    assign peq  = (walk_reg != '0) && eq_reg[pidx];

    // backward scoring step
    logic [NW-1:0]      rl;
    logic [NW-1:0]      sl;
    logic               run_begin;
    logic               sub_begin;
    logic               long4;
    logic               long7;
    logic [NW-1:0]      lit4_n;
    logic [NW-1:0]      lit7_n;
    logic [SCORE_W-1:0] s2_n;
    logic [SCORE_W-1:0] s4_n;
    logic [SCORE_W-1:0] s7_n;
    logic [SCORE_W-1:0] f1;
    logic [SCORE_W-1:0] f4;
    logic [SCORE_W-1:0] f7;
    logic [SCORE_W-1:0] best;
    mode_t              best_mode;

    always_comb
    begin
        rl        = rl_reg + 1'b1;
        sl        = sl_reg + 1'b1;
        run_begin = !pchg || !peq;
        sub_begin = !pchg;
        long4     = rl > NW'(REP_SHORT);
        long7     = rl > NW'(REP_LONG);
        lit4_n    = lit4_reg;
        lit7_n    = lit7_reg;
        s2_n      = s2_reg;
        s4_n      = s4_reg;
        s7_n      = s7_reg;
        if (run_begin)
        begin
            s2_n = s2_reg + SCORE_W'(HDR + 1);
            if (long4)
            begin
                s4_n   = s4_reg + SCORE_W'(HDR + 1)
                       + ((lit4_reg != '0) ? SCORE_W'(HDR) + SCORE_W'(lit4_reg) : '0);
                lit4_n = '0;
            end
            else
            begin
                lit4_n = lit4_reg + rl;
            end
            if (long7)
            begin
                s7_n   = s7_reg + SCORE_W'(HDR + 1)
                       + ((lit7_reg != '0) ? SCORE_W'(HDR) + SCORE_W'(lit7_reg) : '0);
                lit7_n = '0;
            end
            else
            begin
                lit7_n = lit7_reg + rl;
            end
        end
        f1 = SCORE_W'(HDR) + SCORE_W'(sl);
        f4 = s4_n + ((lit4_n != '0) ? SCORE_W'(HDR) + SCORE_W'(lit4_n) : '0);
        f7 = s7_n + ((lit7_n != '0) ? SCORE_W'(HDR) + SCORE_W'(lit7_n) : '0);
        // first best wins ties
        best      = f1;
        best_mode = MODE_LIT;
        if (s2_n < best)
        begin
            best      = s2_n;
            best_mode = MODE_RUNS;
        end
        if (f4 < best)
        begin
            best      = f4;
            best_mode = MODE_REP4;
        end
        if (f7 < best)
        begin
            best      = f7;
            best_mode = MODE_REP7;
        end
    end

    // forward emission step
    logic          start_sub;
    logic          run_start;
    mode_t         m_cur;
    logic [NW-1:0] thr;
    logic          long_now;
    logic [NW-1:0] seg;
    logic          hdr;
    logic          has_tile;
    logic [7:0]    lenb;
    logic [15:0]   map_addr;
    logic [7:0]    ebyte;
    logic          has_byte;
    logic          finish;
    logic          drop;
    logic          out_free;
    logic          byte_ok;
    logic          step_go;
    logic          push;
    logic [7:0]    push_byte;

    always_comb
    begin
        start_sub = chg && !pchg;
        run_start = chg && (!pchg || !peq);
        m_cur     = start_sub ? smode_reg[walk_reg] : emode_reg;
        thr       = (m_cur == MODE_REP4) ? NW'(REP_SHORT) : NW'(REP_LONG);
        long_now  = run_start ? (runlen_reg[walk_reg] > thr) : long_reg;
        seg       = (m_cur == MODE_REP4) ? seg4_reg[walk_reg] : seg7_reg[walk_reg];
        hdr       = 1'b0;
        has_tile  = 1'b0;
        lenb      = 8'(runlen_reg[walk_reg]);
        if (fb_reg)
        begin
            hdr      = (walk_reg == first_reg);
            has_tile = (walk_reg >= first_reg);
            lenb     = 8'(ROW_TILES + LIT_MARK) - 8'(first_reg);
        end
        else if (chg)
        begin
            case (m_cur)
                MODE_LIT:
                begin
                    hdr      = start_sub;
                    has_tile = 1'b1;
                    lenb     = 8'(sublen_reg[walk_reg]) + 8'(LIT_MARK);
                end
                MODE_RUNS:
                begin
                    hdr      = run_start;
                    has_tile = run_start;
                end
                default:
                begin
                    if (long_now)
                    begin
                        hdr      = run_start;
                        has_tile = run_start;
                    end
                    else
                    begin
                        hdr      = run_start && (start_sub || long_reg);
                        has_tile = 1'b1;
                        lenb     = 8'(seg) + 8'(LIT_MARK);
                    end
                end
            endcase
        end
        map_addr = base_reg + rowoff_reg + 16'(walk_reg);
        case (ph_reg)
            2'd0:    ebyte = map_addr[15:8];
            2'd1:    ebyte = map_addr[7:0];
            2'd2:    ebyte = lenb;
            default: ebyte = row_tile_reg[walk_reg];
        endcase
        if (!hdr)
        begin
            ebyte = row_tile_reg[walk_reg];
        end
        has_byte = hdr || has_tile;
        finish   = !hdr || (ph_reg == 2'd3);
        drop     = cnt_reg >= CNT_W'(MAX_OUT);
        out_free = !ov_reg || !byte_stall;
        byte_ok  = drop || !pend_v_reg || out_free;
        step_go  = cmd.emit && (!has_byte || byte_ok);
        push      = 1'b0;
        push_byte = ebyte;
        if (step_go && has_byte)
        begin
            push = 1'b1;
        end
        else if (cmd.fend && byte_ok)
        begin
            push      = 1'b1;
            push_byte = FRAME_TAIL;
        end
    end

    always_comb
    begin
        st.row_last   = (col_reg == LAST_COL);
        st.walk_first = (walk_reg == '0);
        st.any        = any_reg;
        st.frame_last = (row_reg == LAST_ROW);
        st.prime      = prime_reg;
        st.emit_end   = step_go && finish && (walk_reg == LAST_COL);
        st.byte_ok    = byte_ok;
        st.pend_v     = pend_v_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= BASE_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            rowoff_reg  <= '0;
            addr_reg    <= '0;
            changed_reg <= '0;
            pend_v_reg  <= 1'b0;
            cnt_reg     <= '0;
            ov_reg      <= 1'b0;
            any_reg     <= 1'b0;
            fb_reg      <= 1'b0;
        end
        else
        begin
            if (base_we)
            begin
                base_reg <= base_wdata;
            end
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            if (cmd.cmp)
            begin
                changed_reg[col_reg] <= changed_new;
                addr_reg <= (addr_reg == LAST_ADDR) ? '0 : addr_reg + 1'b1;
                if (col_reg != LAST_COL)
                begin
                    col_reg <= col_reg + 1'b1;
                end
                else
                begin
                    any_reg <= 1'b0;
                end
            end
            if (cmd.score && chg && sub_begin)
            begin
                any_reg <= 1'b1;
            end
            if (cmd.decide)
            begin
                fb_reg <= sum_reg >= SCORE_W'(HDR + ROW_TILES) - SCORE_W'(first_reg);
            end
            if (cmd.rowend)
            begin
                changed_reg <= '0;
                col_reg     <= '0;
                if (row_reg == LAST_ROW)
                begin
                    row_reg    <= '0;
                    rowoff_reg <= '0;
                end
                else
                begin
                    row_reg    <= row_reg + 1'b1;
                    rowoff_reg <= rowoff_reg + 16'(MAP_STRIDE);
                end
            end
            // pending byte moves forward on each new byte
            if (push && !drop)
            begin
                cnt_reg    <= cnt_reg + 1'b1;
                pend_v_reg <= 1'b1;
            end
            else if (cmd.flush && pend_v_reg && out_free)
            begin
                pend_v_reg <= 1'b0;
            end
            // output register loads from the pending byte, else drains
            if (pend_v_reg && ((push && !drop) || (cmd.flush && out_free)))
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && !byte_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tile_reg  <= tile_id;
            prime_reg <= req_type;
        end
        if (cmd.cmp)
        begin
            row_tile_reg[col_reg] <= tile_reg;
            last_tile_reg         <= tile_reg;
            if (col_reg != '0)
            begin
                eq_reg[CW'(col_reg - 1'b1)] <= (last_tile_reg == tile_reg);
            end
            walk_reg <= LAST_COL;
            rl_reg   <= '0;
            sl_reg   <= '0;
            lit4_reg <= '0;
            lit7_reg <= '0;
            s2_reg   <= '0;
            s4_reg   <= '0;
            s7_reg   <= '0;
            sum_reg  <= '0;
        end
        if (cmd.score)
        begin
            walk_reg <= pidx;
            if (chg)
            begin
                if (run_begin)
                begin
                    runlen_reg[walk_reg] <= rl;
                    seg4_reg[walk_reg]   <= lit4_n;
                    seg7_reg[walk_reg]   <= lit7_n;
                    rl_reg               <= '0;
                end
                else
                begin
                    rl_reg <= rl;
                end
                if (sub_begin)
                begin
                    smode_reg[walk_reg]  <= best_mode;
                    sublen_reg[walk_reg] <= sl;
                    sum_reg   <= sum_reg + best;
                    first_reg <= walk_reg;
                    sl_reg    <= '0;
                    lit4_reg  <= '0;
                    lit7_reg  <= '0;
                    s2_reg    <= '0;
                    s4_reg    <= '0;
                    s7_reg    <= '0;
                end
                else
                begin
                    sl_reg   <= sl;
                    lit4_reg <= lit4_n;
                    lit7_reg <= lit7_n;
                    s2_reg   <= s2_n;
                    s4_reg   <= s4_n;
                    s7_reg   <= s7_n;
                end
            end
        end
        if (cmd.decide)
        begin
            walk_reg  <= '0;
            ph_reg    <= '0;
            long_reg  <= 1'b0;
            emode_reg <= MODE_LIT;
        end
        if (step_go)
        begin
            if (finish)
            begin
                walk_reg  <= walk_reg + 1'b1;
                ph_reg    <= '0;
                emode_reg <= m_cur;
                long_reg  <= long_now;
            end
            else
            begin
                ph_reg <= ph_reg + 1'b1;
            end
        end
        if (push && !drop)
        begin
            pend_reg <= push_byte;
            if (pend_v_reg)
            begin
                ob_reg <= pend_reg;
                oe_reg <= 1'b0;
            end
        end
        else if (cmd.flush && pend_v_reg && out_free)
        begin
            ob_reg <= pend_reg;
            oe_reg <= 1'b1;
        end
    end

    assign byte_valid = ov_reg;
    assign out_byte   = ob_reg;
    assign end_of_run = oe_reg;

    a_no_pending_at_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !pend_v_reg)
        else $error("pending beat left over when a new item was taken");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_OUT))
        else $error("beat count past limit");

    a_emit_needs_change: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> any_reg)
        else $error("emission walk on a row without changes");

endmodule

>>> rtl/tdpe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdpe_ctrl
// Controller: sequences compare, row scoring, packet emission and row end.
// ----------------------------------------------------------------------------
module tdpe_ctrl
    import tdpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tile_valid,
    output logic       tile_stall,
    input  tdpe_stat_t st,
    output tdpe_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_SCORE,
        ST_DECIDE,
        ST_EMIT,
        ST_FEND,
        ST_FLUSH,
        ST_ROWEND
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = tile_valid;
                if (tile_valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                cmd.cmp    = 1'b1;
                state_next = st.row_last ? ST_SCORE : ST_IDLE;
            end
            ST_SCORE:
            begin
                cmd.score = 1'b1;
                if (st.walk_first)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (st.any)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = (st.frame_last && !st.prime) ? ST_FEND : ST_FLUSH;
                end
            end
            ST_EMIT:
            begin
                cmd.emit = 1'b1;
                if (st.emit_end)
                begin
                    state_next = (st.frame_last && !st.prime) ? ST_FEND : ST_FLUSH;
                end
            end
            ST_FEND:
            begin
                cmd.fend = 1'b1;
                if (st.byte_ok)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                cmd.flush = 1'b1;
                if (!st.pend_v)
                begin
                    state_next = ST_ROWEND;
                end
            end
            ST_ROWEND:
            begin
                cmd.rowend = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign tile_stall = (state_reg != ST_IDLE);

    a_flush_to_rowend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) && !st.pend_v |=> (state_reg == ST_ROWEND))
        else $error("flush did not close the row");

endmodule

>>> rtl/tilemap_delta_packet_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilemap_delta_packet_encoder_top
// Tilemap delta encoder: compares tiles with a stored reference frame and
// emits address/length/tile packets per row of changed tiles.
// ----------------------------------------------------------------------------
// a tile that does not end a row passes the reference read (IDLE) and the compare (CMP)
// a row-ending tile then runs the backward scoring walk and the decide step, then
//   one emission step per output beat or per column without beats, a frame end beat
//   on the last row of an encode frame, a flush and a row close
// one item at a time through the controller; output stalls stretch the emission and flush
// reset: position, change flags and base address (0x9800) clear at once, no sweep
// ----------------------------------------------------------------------------
module tilemap_delta_packet_encoder_top
    import tdpe_pkg::*;
#(
    parameter int ROW_TILES  = ROW_TILES_DEF,
    parameter int ROWS       = ROWS_DEF,
    parameter int MAP_STRIDE = MAP_STRIDE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        base_we,
    input  logic [15:0] base_wdata,
    input  logic        tile_valid,
    output logic        tile_stall,
    input  logic        req_type,
    input  logic [7:0]  tile_id,
    output logic        byte_valid,
    input  logic        byte_stall,
    output logic [7:0]  out_byte,
    output logic        end_of_run
);

    tdpe_cmd_t  cmd;
    tdpe_stat_t st;

    tdpe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tile_valid (tile_valid),
        .tile_stall (tile_stall),
        .st         (st),
        .cmd        (cmd)
    );

    tdpe_dp #(
        .ROW_TILES  (ROW_TILES),
        .ROWS       (ROWS),
        .MAP_STRIDE (MAP_STRIDE)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .base_we    (base_we),
        .base_wdata (base_wdata),
        .req_type   (req_type),
        .tile_id    (tile_id),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .out_byte   (out_byte),
        .end_of_run (end_of_run),
        .cmd        (cmd),
        .st         (st)
    );

endmodule

>>> verif/tilemap_delta_packet_encoder_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilemap_delta_packet_encoder_top_test
// Primes the reference frame, then streams encode and prime tiles through a
// second frame. A packet predictor scores each finished row and checks every
// output beat. Both sides idle at random, and one long output hold-off fills
// the block.
// ----------------------------------------------------------------------------
module tilemap_delta_packet_encoder_top_test;
    import tdpe_pkg::*;

    localparam int NTILES = ROWS_DEF * ROW_TILES_DEF;

    class tdpe_scoreboard;
        logic [15:0] base;
        bit [7:0]    ref_frame [NTILES];
        bit [7:0]    row_buf [ROW_TILES_DEF];
        bit          changed [ROW_TILES_DEF];
        int          col;
        int          row;
        bit [7:0]    pend [$];
        bit [8:0]    exp_q [$];
        int          errors;
        int          beats_seen;
        int          items_seen;

        function new();
            base = BASE_RESET;
            col = 0;
            row = 0;
            errors = 0;
            beats_seen = 0;
            items_seen = 0;
            foreach (changed[i]) changed[i] = 0;
        endfunction

        function void put(int unsigned b);
            if (pend.size() < MAX_OUT)
                pend.push_back(b[7:0]);
        endfunction

        function void header(int unsigned c, int unsigned lb);
            int unsigned a;
            a = (base + row * MAP_STRIDE_DEF + c) & 16'hFFFF;
            put(a >> 8);
            put(a & 8'hFF);
            put(lb);
        endfunction

        function void lit_pkt(int unsigned c, int unsigned n);
            header(c, n + LIT_MARK);
            for (int unsigned i = 0; i < n; i++)
                put(row_buf[(c + i) % ROW_TILES_DEF]);
        endfunction

        function void run_pkt(int unsigned c, int unsigned n);
            header(c, n);
            put(row_buf[c % ROW_TILES_DEF]);
        endfunction

        function int unsigned runs_pack(int unsigned s, int unsigned n, bit send);
            int unsigned c, b, score;
            c = 0;
            score = 0;
            while (c < n)
            begin
                b = c;
                while (c + 1 < n && row_buf[s + c] == row_buf[s + c + 1])
                    c++;
                c++;
                score += HDR + 1;
                if (send)
                    run_pkt(s + b, c - b);
            end
            return score;
        endfunction

        function int unsigned rep_pack(int unsigned s, int unsigned n, int unsigned minlen,
                                       bit send);
            int unsigned p1, p2, c, score;
            p1 = 0;
            c = 0;
            score = 0;
            while (c + 1 < n)
            begin
                if (row_buf[s + c] == row_buf[s + c + 1])
                begin
                    p2 = c;
                    while (c + 1 < n && row_buf[s + c] == row_buf[s + c + 1])
                        c++;
                    if (c - p2 + 1 > minlen)
                    begin
                        if (p2 > p1)
                        begin
                            score += HDR + (p2 - p1);
                            if (send)
                                lit_pkt(s + p1, p2 - p1);
                        end
                        score += HDR + 1;
                        if (send)
                            run_pkt(s + p2, c - p2 + 1);
                        p1 = c + 1;
                    end
                end
                else
                    c++;
            end
            if (p1 != n)
            begin
                score += HDR + (n - p1);
                if (send)
                    lit_pkt(s + p1, n - p1);
            end
            return score;
        endfunction

        // first best mode wins ties
        function mode_t pick_mode(int unsigned s, int unsigned n, output int unsigned sc);
            int unsigned v;
            mode_t m;
            sc = HDR + n;
            m = MODE_LIT;
            v = runs_pack(s, n, 0);
            if (v < sc) begin sc = v; m = MODE_RUNS; end
            v = rep_pack(s, n, REP_SHORT, 0);
            if (v < sc) begin sc = v; m = MODE_REP4; end
            v = rep_pack(s, n, REP_LONG, 0);
            if (v < sc) begin sc = v; m = MODE_REP7; end
            return m;
        endfunction

        function void close_row();
            int unsigned c, s, first, sum, sc;
            bit any;
            mode_t m;
            first = ROW_TILES_DEF;
            sum = 0;
            any = 0;
            for (c = 0; c < ROW_TILES_DEF; c++)
                if (changed[c])
                begin
                    s = c;
                    while (c < ROW_TILES_DEF && changed[c])
                        c++;
                    if (!any) begin first = s; any = 1; end
                    m = pick_mode(s, c - s, sc);
                    sum += sc;
                end
            if (!any)
                return;
            // whole tail as one literal when the packets would not be cheaper
            if (sum >= HDR + ROW_TILES_DEF - first)
            begin
                lit_pkt(first, ROW_TILES_DEF - first);
                return;
            end
            for (c = 0; c < ROW_TILES_DEF; c++)
                if (changed[c])
                begin
                    s = c;
                    while (c < ROW_TILES_DEF && changed[c])
                        c++;
                    m = pick_mode(s, c - s, sc);
                    case (m)
                        MODE_LIT:  lit_pkt(s, c - s);
                        MODE_RUNS: sc = runs_pack(s, c - s, 1);
                        MODE_REP4: sc = rep_pack(s, c - s, REP_SHORT, 1);
                        default:   sc = rep_pack(s, c - s, REP_LONG, 1);
                    endcase
                end
        endfunction

        function void note_tile(bit prime, bit [7:0] tile);
            int idx;
            idx = row * ROW_TILES_DEF + col;
            items_seen++;
            pend.delete();
            row_buf[col] = tile;
            changed[col] = !prime && ref_frame[idx] != tile;
            ref_frame[idx] = tile;
            if (col == ROW_TILES_DEF - 1)
            begin
                close_row();
                foreach (changed[i]) changed[i] = 0;
                if (row == ROWS_DEF - 1 && !prime)
                    put(FRAME_TAIL);
                col = 0;
                row = (row == ROWS_DEF - 1) ? 0 : row + 1;
            end
            else
                col++;
            foreach (pend[i])
                exp_q.push_back({i == pend.size() - 1, pend[i]});
        endfunction

        function void check_beat(bit [7:0] b, bit e);
            bit [8:0] x;
            beats_seen++;
            if (exp_q.size() == 0)
            begin
                $error("unexpected beat out_byte=%h end_of_run=%b", b, e);
                errors++;
                return;
            end
            x = exp_q.pop_front();
            if (x[7:0] !== b)
            begin
                $error("out_byte expected %h actual %h", x[7:0], b);
                errors++;
            end
            if (x[8] !== e)
            begin
                $error("end_of_run expected %b actual %b", x[8], e);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        base_we;
    logic [15:0] base_wdata;
    logic        tile_valid;
    logic        tile_stall;
    logic        req_type;
    logic [7:0]  tile_id;
    logic        byte_valid;
    logic        byte_stall;
    logic [7:0]  out_byte;
    logic        end_of_run;

    tdpe_scoreboard sb = new();
    bit [7:0]       gen_ref [NTILES];
    int             gen_pos = 0;
    bit             steady = 0;
    int             hold_req = 0;

    tilemap_delta_packet_encoder_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .base_we    (base_we),
        .base_wdata (base_wdata),
        .tile_valid (tile_valid),
        .tile_stall (tile_stall),
        .req_type   (req_type),
        .tile_id    (tile_id),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .out_byte   (out_byte),
        .end_of_run (end_of_run)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // accepted beats on both sides
    always @(posedge clk)
    begin
        if (rst_n && tile_valid && !tile_stall)
            sb.note_tile(req_type, tile_id);
        if (rst_n && byte_valid && !byte_stall)
            sb.check_beat(out_byte, end_of_run);
    end

    // output side stall, with one long hold-off on request
    initial
    begin
        int hold;
        hold = 0;
        byte_stall = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold = hold_req;
                hold_req = 0;
            end
            if (hold > 0)
            begin
                byte_stall <= 1;
                hold--;
            end
            else
                byte_stall <= !steady && $urandom_range(99) < 27;
        end
    end

    task automatic send_tile(bit prime, bit [7:0] tile);
        if (!steady && $urandom_range(99) < 27)
        begin
            tile_valid <= 0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        tile_valid <= 1;
        req_type <= prime;
        tile_id <= tile;
        gen_ref[gen_pos] = tile;
        gen_pos = (gen_pos + 1) % NTILES;
        @(posedge clk);
        while (tile_stall)
            @(posedge clk);
    endtask

    // mostly unchanged tiles with runs, so rows reach every packet mode
    task automatic send_random(int count, int prime_pct, bit last_prime);
        bit [7:0] t;
        bit [7:0] prev;
        int       r;
        prev = 0;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 50)
                t = gen_ref[gen_pos];
            else if (r < 75)
                t = prev;
            else if (r < 92)
                t = $urandom_range(3) == 3 ? 8'hFF : 8'($urandom_range(2));
            else
                t = 8'($urandom);
            prev = t;
            send_tile((i == count - 1) ? last_prime : ($urandom_range(99) < prime_pct), t);
        end
        tile_valid <= 0;
    endtask

    task automatic drain();
        int n;
        n = 0;
        while (sb.exp_q.size() != 0 && n < 200000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (100) @(posedge clk);
    endtask

    task automatic write_base(logic [15:0] v);
        drain();
        base_we <= 1;
        base_wdata <= v;
        @(posedge clk);
        base_we <= 0;
        sb.base = v;
    endtask

    initial
    begin
        rst_n = 0;
        base_we = 0;
        base_wdata = 0;
        tile_valid = 0;
        req_type = 0;
        tile_id = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // load the whole reference frame first, nothing is compared before this
        send_random(NTILES, 100, 1);
        drain();

        // directed row: unchanged head, long zero run, extremes, unchanged tail
        for (int c = 0; c < ROW_TILES_DEF; c++)
        begin
            if (c < 5 || c > 16)
                send_tile(0, gen_ref[gen_pos]);
            else if (c < 15)
                send_tile(0, 8'h00);
            else if (c == 15)
                send_tile(0, 8'hFF);
            else
                send_tile(0, ~gen_ref[gen_pos]);
        end

        hold_req = 400;
        send_random(100, 5, 0);
        write_base(16'hFFFF);
        steady = 1;
        send_random(80, 5, 0);
        steady = 0;
        write_base(16'h0000);
        send_random(80, 5, 0);
        write_base(16'($urandom));
        // ends the second frame with an encode tile
        send_random(80, 5, 0);
        drain();

        $display("covered %0d tile beats and %0d packet beats over several base settings",
                 sb.items_seen, sb.beats_seen);
        if (sb.exp_q.size() != 0)
        begin
            $error("%0d beats never arrived", sb.exp_q.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> tilemap_delta_packet_encoder_top.f
rtl/tdpe_pkg.sv
rtl/tdpe_ram.sv
rtl/tdpe_dp.sv
rtl/tdpe_ctrl.sv
rtl/tilemap_delta_packet_encoder_top.sv
verif/tilemap_delta_packet_encoder_top_test.sv
